FILE: hdl/irpwt_pkg.sv
// ----------------------------------------------------------------------------
// irpwt_pkg
// Types and constants shared by the infrared pulse-width transmitter modules.
// ----------------------------------------------------------------------------
package irpwt_pkg;

   // Field widths: burst and pause length counters, bit count, frame word, register index
   localparam int CNT_BITS   = 10;
   localparam int COUNT_BITS = 5;
   localparam int DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;

   // Reset values of the configuration registers
   localparam logic [CNT_BITS-1:0] BREAK_RESET = 10'd288;
   localparam logic [CNT_BITS-1:0] ONE_RESET   = 10'd144;
   localparam logic [CNT_BITS-1:0] ZERO_RESET  = 10'd72;
   localparam logic [CNT_BITS-1:0] PAUSE_RESET = 10'd72;

   // Operation codes of an input word
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BREAK      = 3'd0,
      CSR_ONE        = 3'd1,
      CSR_ZERO       = 3'd2,
      CSR_PAUSE      = 3'd3,
      CSR_ACTIVE_HI  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                  operation;
      logic [DATA_BITS-1:0]  frame_word;
      logic [COUNT_BITS-1:0] bit_count;
   } req_type;

   typedef struct packed {
      logic led_level;
      logic busy_res;
      logic frame_done;
   } rsp_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] break_half_periods;
      logic [CNT_BITS-1:0] one_half_periods;
      logic [CNT_BITS-1:0] zero_half_periods;
      logic [CNT_BITS-1:0] pause_half_periods;
      logic                led_active_high;
   } cfg_type;

   typedef struct packed {
      logic sending;
      logic in_burst;
   } status_type;

endpackage

FILE: hdl/irpwt_csr.sv
// ----------------------------------------------------------------------------
// irpwt_csr
// Configuration register file: burst and pause lengths and LED polarity.
// ----------------------------------------------------------------------------
module irpwt_csr
   import irpwt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CNT_BITS-1:0]       csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index and merge the write word
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BREAK:     cfg_in.break_half_periods = csr_wdata;
            CSR_ONE:       cfg_in.one_half_periods   = csr_wdata;
            CSR_ZERO:      cfg_in.zero_half_periods  = csr_wdata;
            CSR_PAUSE:     cfg_in.pause_half_periods = csr_wdata;
            CSR_ACTIVE_HI: cfg_in.led_active_high    = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.break_half_periods <= BREAK_RESET;
         cfg_ff.one_half_periods   <= ONE_RESET;
         cfg_ff.zero_half_periods  <= ZERO_RESET;
         cfg_ff.pause_half_periods <= PAUSE_RESET;
         cfg_ff.led_active_high    <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/irpwt_core.sv
// ----------------------------------------------------------------------------
// irpwt_core
// Frame sequencer: break burst, data bursts MSB first, pause after each burst.
// ----------------------------------------------------------------------------
module irpwt_core
   import irpwt_pkg::*;
#(
   parameter int WORD_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  req_type    req,
   input  cfg_type    cfg,
   output rsp_type    rsp,
   output status_type status
);

   logic                  sending_ff, sending_in;
   logic                  in_burst_ff, in_burst_in;
   logic                  phase_ff, phase_in;
   logic [CNT_BITS-1:0]   burst_left_ff, burst_left_in;
   logic [CNT_BITS-1:0]   pause_left_ff, pause_left_in;
   logic [WORD_BITS-1:0]  shift_word_ff, shift_word_in;
   logic [COUNT_BITS-1:0] symbols_left_ff, symbols_left_in;
   logic                  done;
   logic [CNT_BITS-1:0]   burst_dec;
   logic [CNT_BITS-1:0]   pause_dec;
   logic [COUNT_BITS-1:0] count_sat;

   assign burst_dec = burst_left_ff - 1'b1;
   assign pause_dec = pause_left_ff - 1'b1;

   // Clamp the bit count to the shift register width
   always_comb begin
      if (32'(req.bit_count) > WORD_BITS) begin
         count_sat = COUNT_BITS'(WORD_BITS);
      end else begin
         count_sat = req.bit_count;
      end
   end

   // Advance the frame by one item
   always_comb begin
      sending_in      = sending_ff;
      in_burst_in     = in_burst_ff;
      phase_in        = phase_ff;
      burst_left_in   = burst_left_ff;
      pause_left_in   = pause_left_ff;
      shift_word_in   = shift_word_ff;
      symbols_left_in = symbols_left_ff;
      done            = 1'b0;
      if (req.operation == OP_START) begin
         // Start while busy is dropped
         if (!sending_ff) begin
            sending_in      = 1'b1;
            in_burst_in     = 1'b1;
            phase_in        = 1'b0;
            burst_left_in   = cfg.break_half_periods;
            pause_left_in   = cfg.pause_half_periods;
            shift_word_in   = WORD_BITS'(req.frame_word);
            symbols_left_in = count_sat;
         end
      end else if (sending_ff) begin
         if (in_burst_ff) begin
            phase_in      = ~phase_ff;
            burst_left_in = burst_dec;
            if (burst_dec == '0) begin
               in_burst_in = 1'b0;
            end
         end else begin
            phase_in      = 1'b0;
            pause_left_in = pause_dec;
            if (pause_dec == '0) begin
               if (symbols_left_ff == '0) begin
                  sending_in = 1'b0;
                  done       = 1'b1;
               end else begin
                  // Load the next data burst from the word MSB
                  symbols_left_in = symbols_left_ff - 1'b1;
                  burst_left_in   = shift_word_ff[WORD_BITS-1] ? cfg.one_half_periods
                                                               : cfg.zero_half_periods;
                  shift_word_in   = {shift_word_ff[WORD_BITS-2:0], 1'b0};
                  pause_left_in   = cfg.pause_half_periods;
                  in_burst_in     = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff      <= 1'b0;
         in_burst_ff     <= 1'b0;
         phase_ff        <= 1'b0;
         burst_left_ff   <= '0;
         pause_left_ff   <= '0;
         shift_word_ff   <= '0;
         symbols_left_ff <= '0;
      end else if (step) begin
         sending_ff      <= sending_in;
         in_burst_ff     <= in_burst_in;
         phase_ff        <= phase_in;
         burst_left_ff   <= burst_left_in;
         pause_left_ff   <= pause_left_in;
         shift_word_ff   <= shift_word_in;
         symbols_left_ff <= symbols_left_in;
      end
   end

   // Apply the LED polarity to the carrier phase
   assign rsp.led_level  = phase_in ^ ~cfg.led_active_high;
   assign rsp.busy_res   = sending_in;
   assign rsp.frame_done = done;

   assign status.sending  = sending_ff;
   assign status.in_burst = in_burst_ff;

endmodule

FILE: hdl/ir_pulse_width_transmitter.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_transmitter
// Infrared pulse-width frame transmitter with carrier-tick input.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : input words. operation 0 is a carrier tick (one half period),
//            operation 1 starts a frame with frame_word and bit_count.
//            A start while a frame is in flight is dropped.
//   rsp_*  : one result word per input word: LED level, busy and frame done.
//   csr_*  : register writes (index 0..4), always ready; write only while idle.
// Path: a word goes into the input register, then through the sequencer
//   logic into the result register.
// Throughput: one word per cycle while rsp_ready stays high; the sequencer
//   state updates once per word, so ticks may arrive back to back.
// Stall: when rsp_ready is low the result register holds and the input
//   register takes one more word, then req_ready drops until rsp drains.
// Reset: synchronous; clears the pipeline, leaves the block idle and loads
//   the default burst and pause lengths and LED polarity.
// ----------------------------------------------------------------------------
module ir_pulse_width_transmitter
   import irpwt_pkg::*;
#(
   parameter int WORD_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CNT_BITS-1:0]       csr_wdata
);

   logic       in_valid_ff;
   req_type    in_data_ff;
   logic       out_valid_ff;
   rsp_type    out_data_ff;
   logic       step;
   cfg_type    cfg;
   rsp_type    core_rsp;
   status_type status;

   // Advance when the result register is free or being drained
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign csr_ready = 1'b1;

   irpwt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   irpwt_core #(
      .WORD_BITS (WORD_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .req    (in_data_ff),
      .cfg    (cfg),
      .rsp    (core_rsp),
      .status (status)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Checks
   a_burst_needs_frame: assert property (@(posedge clock) disable iff (reset)
      !status.sending |-> !status.in_burst)
      else $error("burst active while no frame is in flight");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.frame_done |-> !out_data_ff.busy_res)
      else $error("frame done reported while still busy");

   a_step_fills_result: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed word did not reach the result register");

   a_no_step_when_full: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !step)
      else $error("result overwritten while stalled");

endmodule
